@@ design/point_in_prism_test_macros.svh @@
// Assertion macros used by the point-in-prism test top level.
`ifndef POINT_IN_PRISM_TEST_MACROS_SVH
`define POINT_IN_PRISM_TEST_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PIPT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PIPT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pipt_pkg.sv @@
// Types and constants shared by the point-in-prism test design.
package pipt_pkg;

    localparam int SLOT_W    = 6;
    localparam int ACTION_W  = 2;
    localparam int COEF_W    = 32;
    localparam int VCOUNT_W  = 7;
    localparam int HEIGHT_W  = 31;
    localparam int ROT_FRAC  = 30;
    localparam int ROT_N     = 9;
    localparam int ROT_IDX_W = 4;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = 8;

    localparam logic [ACTION_W-1:0] ACT_VERTEX = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_COEF   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XFORM,
        ST_ZTEST,
        ST_EDGES,
        ST_FINISH
    } pipt_state_t;

    typedef struct packed {
        logic clear;
        logic valid;
        logic first;
        logic last;
    } edge_ctl_t;

    typedef struct packed {
        logic done;
        logic parity;
    } edge_sts_t;

endpackage

@@ design/pipt_edge_unit.sv @@
// Pipelined ray crossing test over a stream of polygon vertices with parity count.
module pipt_edge_unit
    import pipt_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int PT_BITS    = 37
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  edge_ctl_t                    ctl,
    input  logic signed [COORD_BITS-1:0] vx,
    input  logic signed [COORD_BITS-1:0] vy,
    input  logic signed [PT_BITS-1:0]    px,
    input  logic signed [PT_BITS-1:0]    py,
    output edge_sts_t                    sts
);

    localparam int DIF_W = COORD_BITS + 1;
    localparam int OFS_W = PT_BITS + 1;
    localparam int M_W   = DIF_W + OFS_W;
    localparam int N_W   = M_W + 1;

    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;

    logic                    e1_v_reg;
    logic                    e1_last_reg;
    logic                    e1_ok_reg;
    logic                    e1_neg_reg;
    logic signed [DIF_W-1:0] e1_bx_reg;
    logic signed [DIF_W-1:0] e1_by_reg;
    logic signed [DIF_W-1:0] e1_dx_reg;
    logic signed [OFS_W-1:0] e1_dy_reg;

    logic                  e2_v_reg;
    logic                  e2_last_reg;
    logic                  e2_ok_reg;
    logic                  e2_neg_reg;
    logic signed [M_W-1:0] e2_m1_reg;
    logic signed [M_W-1:0] e2_m2_reg;

    logic parity_reg;
    logic done_reg;

    logic signed [DIF_W-1:0]      bx;
    logic signed [DIF_W-1:0]      by;
    logic signed [COORD_BITS-1:0] lo_x;
    logic signed [COORD_BITS-1:0] hi_x;
    logic                         in_range;
    logic signed [OFS_W-1:0]      dx_full;
    logic signed [OFS_W-1:0]      dy;
    logic signed [N_W-1:0]        nv;
    logic                         crossed;

    always_comb
    begin
        bx = DIF_W'(vx) - DIF_W'(prev_x_reg);
        by = DIF_W'(vy) - DIF_W'(prev_y_reg);
        lo_x = (prev_x_reg < vx) ? prev_x_reg : vx;
        hi_x = (prev_x_reg < vx) ? vx : prev_x_reg;
        in_range = !((px < PT_BITS'(lo_x)) || (px > PT_BITS'(hi_x)));
        dx_full = OFS_W'(prev_x_reg) - OFS_W'(px);
        dy = OFS_W'(prev_y_reg) - OFS_W'(py);
        nv = N_W'(e2_m1_reg) - N_W'(e2_m2_reg);
        crossed = e2_ok_reg && ((nv == '0) || (nv[N_W-1] == e2_neg_reg));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            prev_x_reg <= vx;
            prev_y_reg <= vy;
        end
        e1_ok_reg  <= (bx != '0) && in_range;
        e1_neg_reg <= bx[DIF_W-1];
        e1_bx_reg  <= bx;
        e1_by_reg  <= by;
        e1_dx_reg  <= dx_full[DIF_W-1:0];
        e1_dy_reg  <= dy;
        e2_ok_reg  <= e1_ok_reg;
        e2_neg_reg <= e1_neg_reg;
        e2_m1_reg  <= M_W'(e1_by_reg) * M_W'(e1_dx_reg);
        e2_m2_reg  <= M_W'(e1_bx_reg) * M_W'(e1_dy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_v_reg    <= 1'b0;
            e1_last_reg <= 1'b0;
            e2_v_reg    <= 1'b0;
            e2_last_reg <= 1'b0;
            parity_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            e1_v_reg    <= ctl.valid && !ctl.first;
            e1_last_reg <= ctl.valid && ctl.last;
            e2_v_reg    <= e1_v_reg;
            e2_last_reg <= e1_v_reg && e1_last_reg;
            done_reg    <= e2_v_reg && e2_last_reg;
            if (ctl.clear)
            begin
                parity_reg <= 1'b0;
            end
            else if (e2_v_reg && crossed)
            begin
                parity_reg <= !parity_reg;
            end
        end
    end

    assign sts.done   = done_reg;
    assign sts.parity = parity_reg;

endmodule

@@ design/point_in_prism_test.sv @@
// Top level of the point-in-prism test: stores, transform sequencer and result register.
//
// Items arrive on the s_axis channel; tuser selects the kind of transfer. A vertex
// write stores x and y at the given slot, a coefficient write stores one entry of the
// 3x3 rotation, and both return nothing. A query returns exactly one transfer on
// m_axis whose bit 0 is 1 when the point lies inside the prism. For n vertices in
// use, a query runs the transform, which runs its nine products through one
// multiplier fed from the rotation memory, then the height test, then n + 1 reads
// of the vertex memory plus the crossing pipeline, and then loads the result
// register. A point outside the height range, or a vertex count of zero, skips
// the vertex pass. Only one query is in flight; s_axis_tready is high while the
// block is idle, also while an earlier result still waits in the output register.
// If the receiver stalls, a finished query holds until that register is free.
// Configuration writes on the cfg channel are always taken and should only be made
// while the block is idle. Reset sets the vertex count to three and clears origin
// and height; both memories are undefined until written and need no clearing pass.
`include "point_in_prism_test_macros.svh"

module point_in_prism_test
    import pipt_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 32,
    localparam int IN_FIELDS_W = SLOT_W + 3 * COORD_BITS + COEF_W,
    localparam int IN_W        = ((IN_FIELDS_W + 7) / 8) * 8,
    localparam int CFG_W       = (COORD_BITS > 32) ? COORD_BITS : 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // slot, coord_x, coord_y, coord_z, coef_value, zero fill
    input  logic [IN_W-1:0]      s_axis_tdata,
    // action
    input  logic [ACTION_W-1:0]  s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // inside_res, zero fill
    output logic [OUT_W-1:0]     m_axis_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int CW     = COORD_BITS;
    localparam int VIDX   = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int D_W    = CW + 1;
    localparam int PROD_W = COEF_W + D_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int P_W    = ACC_W - ROT_FRAC;

    pipt_state_t state_reg;
    pipt_state_t state_next;

    logic [VCOUNT_W-1:0] vcount_reg;
    logic signed [CW-1:0] origin_x_reg;
    logic signed [CW-1:0] origin_y_reg;
    logic signed [CW-1:0] origin_z_reg;
    logic [HEIGHT_W-1:0] height_reg;

    logic [2*CW-1:0] vmem [0:MAX_VERTICES-1];
    logic [2*CW-1:0] vq_reg;
    logic [COEF_W-1:0] rmem [0:ROT_N-1];
    logic [COEF_W-1:0] rq_reg;

    logic [ACTION_W-1:0] in_action;
    logic [SLOT_W-1:0] in_slot;
    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
    logic signed [CW-1:0] in_z;
    logic [COEF_W-1:0] in_coef;
    logic in_fire;

    logic signed [D_W-1:0] dx_reg;
    logic signed [D_W-1:0] dy_reg;
    logic signed [D_W-1:0] dz_reg;

    logic [1:0] row_reg;
    logic [1:0] col_reg;
    logic xf_iss_reg;
    logic rr_v_reg;
    logic [1:0] rr_row_reg;
    logic [1:0] rr_col_reg;
    logic pr_v_reg;
    logic [1:0] pr_row_reg;
    logic [1:0] pr_col_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [P_W-1:0] px_reg;
    logic signed [P_W-1:0] py_reg;
    logic signed [P_W-1:0] pz_reg;

    logic [CNT_W-1:0] ecnt_reg;
    logic e_iss_reg;
    edge_ctl_t ctl_reg;
    edge_sts_t edge_sts;

    logic res_reg;
    logic m_valid_reg;
    logic out_res_reg;

    logic [CNT_W-1:0] n_cnt;
    logic [ROT_IDX_W-1:0] rot_raddr;
    logic signed [D_W-1:0] d_sel;
    logic signed [ACC_W-1:0] acc_sum;
    logic acc_last;
    logic z_out;
    logic [VIDX-1:0] vraddr;
    logic out_load;
    logic edge_start;

    assign in_action = s_axis_tuser;
    assign in_slot   = s_axis_tdata[SLOT_W-1:0];
    assign in_x      = s_axis_tdata[SLOT_W +: CW];
    assign in_y      = s_axis_tdata[SLOT_W + CW +: CW];
    assign in_z      = s_axis_tdata[SLOT_W + 2 * CW +: CW];
    assign in_coef   = s_axis_tdata[SLOT_W + 3 * CW +: COEF_W];
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        n_cnt = (32'(vcount_reg) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(vcount_reg);
        rot_raddr = ROT_IDX_W'({row_reg, 1'b0}) + ROT_IDX_W'(row_reg) + ROT_IDX_W'(col_reg);
        case (rr_col_reg)
            2'd0:    d_sel = dx_reg;
            2'd1:    d_sel = dy_reg;
            default: d_sel = dz_reg;
        endcase
        acc_sum = ((pr_col_reg == 2'd0) ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);
        acc_last = pr_v_reg && (pr_row_reg == 2'd2) && (pr_col_reg == 2'd2);
        z_out = pz_reg[P_W-1] || ($signed(64'(pz_reg)) > $signed({33'd0, height_reg}));
        vraddr = (ecnt_reg == n_cnt) ? VIDX'(0) : ecnt_reg[VIDX-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        s_axis_tready = 1'b0;
        out_load = 1'b0;
        edge_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && (in_action == ACT_QUERY))
                begin
                    state_next = ST_XFORM;
                end
            end
            ST_XFORM:
            begin
                if (acc_last)
                begin
                    state_next = ST_ZTEST;
                end
            end
            ST_ZTEST:
            begin
                if (z_out || (n_cnt == '0))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    edge_start = 1'b1;
                    state_next = ST_EDGES;
                end
            end
            ST_EDGES:
            begin
                if (edge_sts.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg   <= VCOUNT_W'(3);
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            height_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_VCOUNT:   vcount_reg   <= cfg_data[VCOUNT_W-1:0];
                CFG_ORIGIN_X: origin_x_reg <= cfg_data[CW-1:0];
                CFG_ORIGIN_Y: origin_y_reg <= cfg_data[CW-1:0];
                CFG_ORIGIN_Z: origin_z_reg <= cfg_data[CW-1:0];
                CFG_HEIGHT:   height_reg   <= cfg_data[HEIGHT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (in_action == ACT_VERTEX) && (32'(in_slot) < MAX_VERTICES))
        begin
            vmem[VIDX'(in_slot)] <= {in_y, in_x};
        end
        if ((state_reg == ST_EDGES) && e_iss_reg)
        begin
            vq_reg <= vmem[vraddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (in_action == ACT_COEF) && (32'(in_slot) < ROT_N))
        begin
            rmem[ROT_IDX_W'(in_slot)] <= in_coef;
        end
        if ((state_reg == ST_XFORM) && xf_iss_reg)
        begin
            rq_reg <= rmem[rot_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (in_action == ACT_QUERY))
        begin
            dx_reg <= D_W'(in_x) - D_W'(origin_x_reg);
            dy_reg <= D_W'(in_y) - D_W'(origin_y_reg);
            dz_reg <= D_W'(in_z) - D_W'(origin_z_reg);
        end
        prod_reg <= PROD_W'($signed(rq_reg)) * PROD_W'(d_sel);
        if (pr_v_reg)
        begin
            acc_reg <= acc_sum;
            if (pr_col_reg == 2'd2)
            begin
                case (pr_row_reg)
                    2'd0:    px_reg <= acc_sum[ACC_W-1:ROT_FRAC];
                    2'd1:    py_reg <= acc_sum[ACC_W-1:ROT_FRAC];
                    default: pz_reg <= acc_sum[ACC_W-1:ROT_FRAC];
                endcase
            end
        end
        rr_row_reg <= row_reg;
        rr_col_reg <= col_reg;
        pr_row_reg <= rr_row_reg;
        pr_col_reg <= rr_col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            xf_iss_reg  <= 1'b0;
            rr_v_reg    <= 1'b0;
            pr_v_reg    <= 1'b0;
            ecnt_reg    <= '0;
            e_iss_reg   <= 1'b0;
            ctl_reg     <= '0;
            res_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            out_res_reg <= 1'b0;
        end
        else
        begin
            rr_v_reg <= (state_reg == ST_XFORM) && xf_iss_reg;
            pr_v_reg <= rr_v_reg;
            if (in_fire && (in_action == ACT_QUERY))
            begin
                row_reg    <= '0;
                col_reg    <= '0;
                xf_iss_reg <= 1'b1;
            end
            else if ((state_reg == ST_XFORM) && xf_iss_reg)
            begin
                if (col_reg == 2'd2)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 2'd1;
                    if (row_reg == 2'd2)
                    begin
                        xf_iss_reg <= 1'b0;
                    end
                end
                else
                begin
                    col_reg <= col_reg + 2'd1;
                end
            end

            ctl_reg.clear <= edge_start;
            ctl_reg.valid <= (state_reg == ST_EDGES) && e_iss_reg;
            ctl_reg.first <= ecnt_reg == '0;
            ctl_reg.last  <= ecnt_reg == n_cnt;
            if (edge_start)
            begin
                ecnt_reg  <= '0;
                e_iss_reg <= 1'b1;
            end
            else if ((state_reg == ST_EDGES) && e_iss_reg)
            begin
                ecnt_reg <= ecnt_reg + CNT_W'(1);
                if (ecnt_reg == n_cnt)
                begin
                    e_iss_reg <= 1'b0;
                end
            end

            if (state_reg == ST_ZTEST)
            begin
                res_reg <= 1'b0;
            end
            else if ((state_reg == ST_EDGES) && edge_sts.done)
            begin
                res_reg <= edge_sts.parity;
            end

            if (out_load)
            begin
                m_valid_reg <= 1'b1;
                out_res_reg <= res_reg;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    pipt_edge_unit #(
        .COORD_BITS (CW),
        .PT_BITS    (P_W)
    ) u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_reg),
        .vx    (vq_reg[CW-1:0]),
        .vy    (vq_reg[2*CW-1:CW]),
        .px    (px_reg),
        .py    (py_reg),
        .sts   (edge_sts)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_W-1){1'b0}}, out_res_reg};

    `PIPT_ASSERT_IMP(a_out_no_overwrite, out_load, !m_valid_reg || m_axis_tready,
        "result register overwritten while a transfer is pending")
    `PIPT_ASSERT_NEXT(a_query_starts, in_fire && (in_action == ACT_QUERY),
        (state_reg == ST_XFORM) && xf_iss_reg, "accepted query did not start the transform")
    `PIPT_ASSERT_IMP(a_done_in_edges, edge_sts.done, state_reg == ST_EDGES,
        "edge pass finished outside the edge state")
    `PIPT_ASSERT_IMP(a_xform_quiet, (state_reg != ST_XFORM), !xf_iss_reg || (state_reg == ST_IDLE),
        "rotation reads issued outside the transform")

endmodule
